// ===== rtl/core/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;

	localparam int MEM_AW    = 10;
	localparam int MEM_WORDS = 1 << MEM_AW;
	localparam int CLR_W     = (MEM_AW > 5) ? MEM_AW : 5;

	typedef enum logic [5:0] {
		OP_ADD   = 6'd0,  OP_ADDU  = 6'd1,  OP_ADDI  = 6'd2,  OP_ADDIU = 6'd3,
		OP_AND   = 6'd4,  OP_ANDI  = 6'd5,  OP_DIV   = 6'd6,  OP_DIVU  = 6'd7,
		OP_LB    = 6'd8,  OP_LBU   = 6'd9,  OP_LH    = 6'd10, OP_LHU   = 6'd11,
		OP_LUI   = 6'd12, OP_LW    = 6'd13, OP_LWU   = 6'd14, OP_MFHI  = 6'd15,
		OP_MFLO  = 6'd16, OP_MTHI  = 6'd17, OP_MTLO  = 6'd18, OP_MULT  = 6'd19,
		OP_MULTU = 6'd20, OP_NOR   = 6'd21, OP_OR    = 6'd22, OP_ORI   = 6'd23,
		OP_SB    = 6'd24, OP_SH    = 6'd25, OP_SLL   = 6'd26, OP_SLLV  = 6'd27,
		OP_SLT   = 6'd28, OP_SLTI  = 6'd29, OP_SLTIU = 6'd30, OP_SLTU  = 6'd31,
		OP_SRA   = 6'd32, OP_SRAV  = 6'd33, OP_SRL   = 6'd34, OP_SRLV  = 6'd35,
		OP_SUB   = 6'd36, OP_SUBU  = 6'd37, OP_SW    = 6'd38, OP_XOR   = 6'd39,
		OP_XORI  = 6'd40
	} op_e;

	typedef enum logic [2:0] {
		CLS_ALU, CLS_MTHI, CLS_MTLO, CLS_MUL, CLS_DIV, CLS_LOAD, CLS_STORE, CLS_BAD
	} cls_e;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_BAD  = 2'd2
	} status_e;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_MEM, S_MUL, S_MULFIX, S_DIV, S_DIVFIX, S_DONE
	} bstate_e;

	typedef struct packed {
		logic [5:0]  kind;
		logic [4:0]  src_reg_s;
		logic [4:0]  src_reg_t;
		logic [4:0]  dst_reg_d;
		logic [15:0] immediate;
		logic [4:0]  shift_amount;
	} in_t;

	typedef struct packed {
		logic        reg_write;
		logic [4:0]  reg_index;
		logic [31:0] reg_value;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic [1:0]  status;
	} out_t;

	// decoded request as it travels from front to back
	typedef struct packed {
		op_e         op;
		cls_e        cls;
		logic        sgn;
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  dst;
		logic [15:0] imm;
		logic [4:0]  sa;
	} dec_t;

	typedef struct packed {
		logic clearing;
	} bk_stat_t;

endpackage

// ===== rtl/core/mie_ram.sv =====
`timescale 1ns / 1ps
module mie_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/mie_front.sv =====
`timescale 1ns / 1ps
module mie_front
	import mie_pkg::*;
(
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  logic clearing,
	input  logic q_full,
	output logic push,
	output dec_t push_data
);

	always_comb begin
		in_ready = !q_full && !clearing;
		push     = in_valid && in_ready;

		push_data.op  = op_e'(in_data.kind);
		push_data.rs  = in_data.src_reg_s;
		push_data.rt  = in_data.src_reg_t;
		push_data.imm = in_data.immediate;
		push_data.sa  = in_data.shift_amount;
		push_data.sgn = 1'b0;
		push_data.cls = CLS_ALU;
		push_data.dst = in_data.dst_reg_d;

		case (op_e'(in_data.kind)) inside
			OP_ADDI, OP_ADDIU, OP_ANDI, OP_LUI, OP_ORI, OP_SLTI, OP_SLTIU, OP_XORI: begin
				push_data.dst = in_data.src_reg_t;
			end
			OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWU: begin
				push_data.dst = in_data.src_reg_t;
				push_data.cls = CLS_LOAD;
			end
			OP_SB, OP_SH, OP_SW: push_data.cls = CLS_STORE;
			OP_MTHI: push_data.cls = CLS_MTHI;
			OP_MTLO: push_data.cls = CLS_MTLO;
			OP_MULT: begin
				push_data.cls = CLS_MUL;
				push_data.sgn = 1'b1;
			end
			OP_MULTU: push_data.cls = CLS_MUL;
			OP_DIV: begin
				push_data.cls = CLS_DIV;
				push_data.sgn = 1'b1;
			end
			OP_DIVU: push_data.cls = CLS_DIV;
			OP_ADD, OP_ADDU, OP_AND, OP_MFHI, OP_MFLO, OP_NOR, OP_OR, OP_SLL, OP_SLLV,
			OP_SLT, OP_SLTU, OP_SRA, OP_SRAV, OP_SRL, OP_SRLV, OP_SUB, OP_SUBU,
			OP_XOR: push_data.cls = CLS_ALU;
			default: push_data.cls = CLS_BAD;
		endcase
	end

endmodule

// ===== rtl/core/mie_queue.sv =====
`timescale 1ns / 1ps
module mie_queue
	import mie_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t push_data,
	output logic full,
	output logic valid,
	output dec_t data,
	input  logic pop
);

	dec_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign data  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/mie_back.sv =====
`timescale 1ns / 1ps
module mie_back
	import mie_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  dec_t     q_data,
	output logic     q_pop,
	output logic     out_valid,
	input  logic     out_ready,
	output out_t     out_data,
	output bk_stat_t stat
);

	bstate_e state_q, state_d;
	dec_t        cur_q;
	logic [31:0] hi_q, lo_q;
	logic [31:0] b_q, ma_q, mb_q;
	logic        negq_q, negr_q;
	logic [63:0] prod_q;
	logic [31:0] rem_q, quo_q;
	logic [4:0]  cnt_q;
	logic [1:0]  alo_q;
	logic [MEM_AW-1:0] widx_q;
	logic [CLR_W-1:0]  clr_q;
	logic        rw_q;
	logic [4:0]  ridx_q;
	logic [31:0] rval_q;
	status_e     rst_q;

	logic [31:0] rfa_rdata, rfb_rdata, mem_rdata;
	logic        rf_we, mem_we;
	logic [4:0]  rf_waddr;
	logic [31:0] rf_wdata, mem_wdata;
	logic [MEM_AW-1:0] mem_waddr;

	logic [31:0] a, b, simm, addr, alu, ldv, ma, mb;
	logic [4:0]  sh;
	logic [32:0] trial;
	logic        take;

	// operands: register 0 reads zero
	always_comb begin
		a     = (cur_q.rs == 5'd0) ? 32'd0 : rfa_rdata;
		b     = (cur_q.rt == 5'd0) ? 32'd0 : rfb_rdata;
		simm  = {{16{cur_q.imm[15]}}, cur_q.imm};
		addr  = a + simm;
		ma    = (cur_q.sgn && a[31]) ? (32'd0 - a) : a;
		mb    = (cur_q.sgn && b[31]) ? (32'd0 - b) : b;
		trial = {rem_q, quo_q[31]};
		take  = (trial >= {1'b0, mb_q});

		sh = cur_q.sa;
		case (cur_q.op) inside
			OP_SLLV, OP_SRAV, OP_SRLV: sh = a[4:0];
			default: sh = cur_q.sa;
		endcase

		case (cur_q.op)
			OP_ADD, OP_ADDU:   alu = a + b;
			OP_ADDI, OP_ADDIU: alu = a + simm;
			OP_SUB, OP_SUBU:   alu = a - b;
			OP_AND:            alu = a & b;
			OP_ANDI:           alu = a & {16'd0, cur_q.imm};
			OP_OR:             alu = a | b;
			OP_ORI:            alu = a | {16'd0, cur_q.imm};
			OP_XOR:            alu = a ^ b;
			OP_XORI:           alu = a ^ {16'd0, cur_q.imm};
			OP_NOR:            alu = ~(a | b);
			OP_LUI:            alu = {cur_q.imm, 16'd0};
			OP_SLT:            alu = {31'd0, $signed(a) < $signed(b)};
			OP_SLTI:           alu = {31'd0, $signed(a) < $signed(simm)};
			OP_SLTIU:          alu = {31'd0, a < simm};
			OP_SLTU:           alu = {31'd0, a < b};
			OP_SLL, OP_SLLV:   alu = b << sh;
			OP_SRL, OP_SRLV:   alu = b >> sh;
			OP_SRA, OP_SRAV:   alu = $unsigned($signed(b) >>> sh);
			OP_MFHI:           alu = hi_q;
			OP_MFLO:           alu = lo_q;
			default:           alu = 32'd0;
		endcase

		// big-endian lane select on the fetched word
		case (cur_q.op)
			OP_LB: begin
				case (alo_q)
					2'd0:    ldv = {{24{mem_rdata[31]}}, mem_rdata[31:24]};
					2'd1:    ldv = {{24{mem_rdata[23]}}, mem_rdata[23:16]};
					2'd2:    ldv = {{24{mem_rdata[15]}}, mem_rdata[15:8]};
					default: ldv = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
				endcase
			end
			OP_LBU: begin
				case (alo_q)
					2'd0:    ldv = {24'd0, mem_rdata[31:24]};
					2'd1:    ldv = {24'd0, mem_rdata[23:16]};
					2'd2:    ldv = {24'd0, mem_rdata[15:8]};
					default: ldv = {24'd0, mem_rdata[7:0]};
				endcase
			end
			OP_LH:  ldv = alo_q[1] ? {{16{mem_rdata[15]}}, mem_rdata[15:0]}
			                       : {{16{mem_rdata[31]}}, mem_rdata[31:16]};
			OP_LHU: ldv = alo_q[1] ? {16'd0, mem_rdata[15:0]} : {16'd0, mem_rdata[31:16]};
			default: ldv = mem_rdata;
		endcase

		case (cur_q.op)
			OP_SB: begin
				case (alo_q)
					2'd0:    mem_wdata = {b_q[7:0], mem_rdata[23:0]};
					2'd1:    mem_wdata = {mem_rdata[31:24], b_q[7:0], mem_rdata[15:0]};
					2'd2:    mem_wdata = {mem_rdata[31:16], b_q[7:0], mem_rdata[7:0]};
					default: mem_wdata = {mem_rdata[31:8], b_q[7:0]};
				endcase
			end
			OP_SH:   mem_wdata = alo_q[1] ? {mem_rdata[31:16], b_q[15:0]}
			                              : {b_q[15:0], mem_rdata[15:0]};
			default: mem_wdata = b_q;
		endcase
	end

	// next state and port controls
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		rf_we     = 1'b0;
		rf_waddr  = cur_q.dst;
		rf_wdata  = alu;
		mem_we    = 1'b0;
		mem_waddr = widx_q;
		case (state_q)
			S_CLEAR: begin
				rf_we     = 1'b1;
				rf_waddr  = clr_q[4:0];
				rf_wdata  = 32'd0;
				mem_we    = 1'b1;
				mem_waddr = clr_q[MEM_AW-1:0];
				if (clr_q == {CLR_W{1'b1}}) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cur_q.cls)
					CLS_ALU: begin
						rf_we   = (cur_q.dst != 5'd0);
						state_d = S_DONE;
					end
					CLS_LOAD, CLS_STORE: state_d = S_MEM;
					CLS_MUL:             state_d = S_MUL;
					CLS_DIV:             state_d = (b == 32'd0) ? S_DONE : S_DIV;
					default:             state_d = S_DONE;
				endcase
			end
			S_MEM: begin
				if (cur_q.cls == CLS_LOAD) begin
					rf_we    = (cur_q.dst != 5'd0);
					rf_wdata = ldv;
				end else begin
					mem_we = 1'b1;
				end
				state_d = S_DONE;
			end
			S_MUL:    state_d = S_MULFIX;
			S_MULFIX: state_d = S_DONE;
			S_DIV: begin
				if (cnt_q == 5'd0) begin
					state_d = S_DIVFIX;
				end
			end
			S_DIVFIX: state_d = S_DONE;
			S_DONE: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hi_q    <= 32'd0;
			lo_q    <= 32'd0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_EXEC && cur_q.cls == CLS_MTHI) begin
				hi_q <= a;
			end
			if (state_q == S_EXEC && cur_q.cls == CLS_MTLO) begin
				lo_q <= a;
			end
			if (state_q == S_MULFIX) begin
				{hi_q, lo_q} <= negq_q ? (64'd0 - prod_q) : prod_q;
			end
			if (state_q == S_DIVFIX) begin
				lo_q <= negq_q ? (32'd0 - quo_q) : quo_q;
				hi_q <= negr_q ? (32'd0 - rem_q) : rem_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cur_q <= q_data;
			end
			S_EXEC: begin
				b_q    <= b;
				ma_q   <= ma;
				mb_q   <= mb;
				negq_q <= cur_q.sgn && (a[31] ^ b[31]);
				negr_q <= cur_q.sgn && a[31];
				alo_q  <= addr[1:0];
				widx_q <= addr[MEM_AW+1:2];
				rem_q  <= 32'd0;
				quo_q  <= ma;
				cnt_q  <= 5'd31;
				rw_q   <= (cur_q.cls == CLS_ALU) && (cur_q.dst != 5'd0);
				ridx_q <= ((cur_q.cls == CLS_ALU) && (cur_q.dst != 5'd0)) ? cur_q.dst : 5'd0;
				rval_q <= ((cur_q.cls == CLS_ALU) && (cur_q.dst != 5'd0)) ? alu : 32'd0;
				if (cur_q.cls == CLS_BAD) begin
					rst_q <= ST_BAD;
				end else if (cur_q.cls == CLS_DIV && b == 32'd0) begin
					rst_q <= ST_DIV0;
				end else begin
					rst_q <= ST_OK;
				end
			end
			S_MEM: begin
				if (cur_q.cls == CLS_LOAD && cur_q.dst != 5'd0) begin
					rw_q   <= 1'b1;
					ridx_q <= cur_q.dst;
					rval_q <= ldv;
				end
			end
			S_MUL: begin
				prod_q <= ma_q * mb_q;
			end
			S_DIV: begin
				rem_q <= take ? 32'(trial - {1'b0, mb_q}) : trial[31:0];
				quo_q <= {quo_q[30:0], take};
				cnt_q <= cnt_q - 5'd1;
			end
			default: begin
			end
		endcase
	end

	mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
		.clk  (clk),
		.we   (rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.raddr(q_data.rs),
		.rdata(rfa_rdata)
	);

	mie_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
		.clk  (clk),
		.we   (rf_we),
		.waddr(rf_waddr),
		.wdata(rf_wdata),
		.raddr(q_data.rt),
		.rdata(rfb_rdata)
	);

	mie_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dmem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata((state_q == S_CLEAR) ? 32'd0 : mem_wdata),
		.raddr(addr[MEM_AW+1:2]),
		.rdata(mem_rdata)
	);

	always_comb begin
		out_valid          = (state_q == S_DONE);
		out_data.reg_write = rw_q;
		out_data.reg_index = ridx_q;
		out_data.reg_value = rval_q;
		out_data.hi_value  = hi_q;
		out_data.lo_value  = lo_q;
		out_data.status    = rst_q;
		stat.clearing      = (state_q == S_CLEAR);
	end

endmodule

// ===== rtl/core/mips_integer_execute_unit_top.sv =====
`timescale 1ns / 1ps
// channel | handshake            | payload
// in      | in_valid / in_ready   | in_data  (in_t: decoded instruction)
// out     | out_valid / out_ready | out_data (out_t: register write, hi/lo, status)
//
// alu ops go from pop through execute to result; loads and stores add a memory step, mult
// a 32x32 multiply plus sign fix, div a sign fix after its loop (one quotient bit per cycle)
// after reset a clearing pass zeroes the register file and all MEM_WORDS (1024) words
// of the data memory, during which in_ready stays low
// a two-entry queue lets the front take requests while the back is busy
// or while a finished result waits on out_ready
module mips_integer_execute_unit_top
	import mie_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic     q_full, q_valid, push, pop;
	dec_t     push_data, q_data;
	bk_stat_t stat;

	// accept and classify
	mie_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.clearing (stat.clearing),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	// decoupling queue
	mie_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.valid    (q_valid),
		.data     (q_data),
		.pop      (pop)
	);

	// execute, register file, hi/lo, data memory
	mie_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.stat     (stat)
	);

	// no request taken while memories are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !in_ready) else $error("request accepted during clear");

	// register 0 is never reported as written
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.reg_write) |-> (out_data.reg_index != 5'd0))
		else $error("write to register 0 reported");

	// failed operations write no register
	a_err_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ST_OK) |-> !out_data.reg_write)
		else $error("register write on error status");

	// result held while the back is stalled
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed under stall");

endmodule

// ===== test/mips_integer_execute_unit_top_tb.sv =====
`timescale 1ns / 1ps
module mips_integer_execute_unit_top_tb;
	import mie_pkg::*;

	// expected-result store plus the architectural state that predicts it
	class exec_scoreboard;
		logic [31:0] gpr [32];
		logic [31:0] hi_q, lo_q;
		logic [31:0] dmem [MEM_WORDS];
		out_t pending [$];
		int errors;
		int checked;

		function void clear_state();
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			hi_q = '0;
			lo_q = '0;
			errors = 0;
			checked = 0;
		endfunction

		function logic [31:0] sra32(logic [31:0] v, logic [4:0] sh);
			return $unsigned($signed(v) >>> sh);
		endfunction

		// apply one accepted request to the state and queue what it produces
		function void note_request(in_t r);
			out_t o;
			logic [31:0] a, b, simm, zimm, addr, word, wval, q, rm, ma, mb;
			logic [63:0] prod;
			logic [4:0] bsh, hsh, wdst;
			int widx;
			logic wr;
			a = (r.src_reg_s == 0) ? 32'd0 : gpr[r.src_reg_s];
			b = (r.src_reg_t == 0) ? 32'd0 : gpr[r.src_reg_t];
			simm = {{16{r.immediate[15]}}, r.immediate};
			zimm = {16'd0, r.immediate};
			addr = a + simm;
			widx = (addr >> 2) % MEM_WORDS;
			word = dmem[widx];
			bsh = 5'd24 - 5'd8 * addr[1:0];
			hsh = addr[1] ? 5'd0 : 5'd16;
			wr = 1'b0;
			wdst = r.dst_reg_d;
			wval = '0;
			o = '0;
			o.status = ST_OK;
			case (r.kind)
				OP_ADD, OP_ADDU: begin wr = 1; wval = a + b; end
				OP_ADDI, OP_ADDIU: begin wr = 1; wdst = r.src_reg_t; wval = a + simm; end
				OP_AND: begin wr = 1; wval = a & b; end
				OP_ANDI: begin wr = 1; wdst = r.src_reg_t; wval = a & zimm; end
				OP_DIV: begin
					if (b == 0) o.status = ST_DIV0;
					else begin
						ma = a[31] ? -a : a;
						mb = b[31] ? -b : b;
						q = ma / mb;
						rm = ma % mb;
						lo_q = (a[31] != b[31]) ? -q : q;
						hi_q = a[31] ? -rm : rm;
					end
				end
				OP_DIVU: begin
					if (b == 0) o.status = ST_DIV0;
					else begin lo_q = a / b; hi_q = a % b; end
				end
				OP_LB: begin
					wr = 1; wdst = r.src_reg_t;
					q = word >> bsh;
					wval = {{24{q[7]}}, q[7:0]};
				end
				OP_LBU: begin wr = 1; wdst = r.src_reg_t; q = word >> bsh; wval = {24'd0, q[7:0]}; end
				OP_LH: begin
					wr = 1; wdst = r.src_reg_t;
					q = word >> hsh;
					wval = {{16{q[15]}}, q[15:0]};
				end
				OP_LHU: begin wr = 1; wdst = r.src_reg_t; q = word >> hsh; wval = {16'd0, q[15:0]}; end
				OP_LUI: begin wr = 1; wdst = r.src_reg_t; wval = {r.immediate, 16'd0}; end
				OP_LW, OP_LWU: begin wr = 1; wdst = r.src_reg_t; wval = word; end
				OP_MFHI: begin wr = 1; wval = hi_q; end
				OP_MFLO: begin wr = 1; wval = lo_q; end
				OP_MTHI: hi_q = a;
				OP_MTLO: lo_q = a;
				OP_MULT: begin
					prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
					lo_q = prod[31:0]; hi_q = prod[63:32];
				end
				OP_MULTU: begin
					prod = {32'd0, a} * {32'd0, b};
					lo_q = prod[31:0]; hi_q = prod[63:32];
				end
				OP_NOR: begin wr = 1; wval = ~(a | b); end
				OP_OR: begin wr = 1; wval = a | b; end
				OP_ORI: begin wr = 1; wdst = r.src_reg_t; wval = a | zimm; end
				OP_SB: dmem[widx] = (word & ~(32'hFF << bsh)) | ({24'd0, b[7:0]} << bsh);
				OP_SH: dmem[widx] = (word & ~(32'hFFFF << hsh)) | ({16'd0, b[15:0]} << hsh);
				OP_SLL: begin wr = 1; wval = b << r.shift_amount; end
				OP_SLLV: begin wr = 1; wval = b << a[4:0]; end
				OP_SLT: begin wr = 1; wval = {31'd0, $signed(a) < $signed(b)}; end
				OP_SLTI: begin wr = 1; wdst = r.src_reg_t; wval = {31'd0, $signed(a) < $signed(simm)}; end
				OP_SLTIU: begin wr = 1; wdst = r.src_reg_t; wval = {31'd0, a < simm}; end
				OP_SLTU: begin wr = 1; wval = {31'd0, a < b}; end
				OP_SRA: begin wr = 1; wval = sra32(b, r.shift_amount); end
				OP_SRAV: begin wr = 1; wval = sra32(b, a[4:0]); end
				OP_SRL: begin wr = 1; wval = b >> r.shift_amount; end
				OP_SRLV: begin wr = 1; wval = b >> a[4:0]; end
				OP_SUB, OP_SUBU: begin wr = 1; wval = a - b; end
				OP_SW: dmem[widx] = b;
				OP_XOR: begin wr = 1; wval = a ^ b; end
				OP_XORI: begin wr = 1; wdst = r.src_reg_t; wval = a ^ zimm; end
				default: o.status = ST_BAD;
			endcase
			// writes to register zero are dropped and not reported
			if (wr && wdst != 0) begin
				gpr[wdst] = wval;
				o.reg_write = 1'b1;
				o.reg_index = wdst;
				o.reg_value = wval;
			end
			o.hi_value = hi_q;
			o.lo_value = lo_q;
			pending.push_back(o);
		endfunction

		function void check_result(out_t got);
			out_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (got.reg_write !== exp.reg_write || got.reg_index !== exp.reg_index ||
					got.reg_value !== exp.reg_value) begin
				$display("%0t: reg write exp %b/%0d/%h got %b/%0d/%h", $realtime,
					exp.reg_write, exp.reg_index, exp.reg_value,
					got.reg_write, got.reg_index, got.reg_value);
				errors++;
			end
			if (got.hi_value !== exp.hi_value || got.lo_value !== exp.lo_value) begin
				$display("%0t: hi/lo exp %h/%h got %h/%h", $realtime,
					exp.hi_value, exp.lo_value, got.hi_value, got.lo_value);
				errors++;
			end
			if (got.status !== exp.status) begin
				$display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	exec_scoreboard sb;
	int send_idle_pct;   // chance per cycle that the sender holds back
	int recv_idle_pct;   // chance per cycle that the receiver stalls
	bit hold_phase;      // asks the receiver for one long stall
	int sent;

	mips_integer_execute_unit_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop: clearing pass plus ~800 requests, divides the longest, with stalls
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stalls, plus one long hold-off counted here
	initial begin
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (hold_phase && !hold_done) begin
				hold_left = 200;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one request, holding it steady until accepted; gaps at random
	task automatic send_request(in_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(r);
		sent++;
	endtask

	function automatic in_t make_request(logic [5:0] k, int s, int t, int d, int imm, int sa);
		in_t r;
		r.kind = k;
		r.src_reg_s = 5'(s);
		r.src_reg_t = 5'(t);
		r.dst_reg_d = 5'(d);
		r.immediate = 16'(imm);
		r.shift_amount = 5'(sa);
		return r;
	endfunction

	// mostly real opcodes on a few registers so values chain, small addresses
	// so loads see earlier stores, occasionally fully random bits
	function automatic in_t random_request();
		in_t r;
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		r = raw[$bits(in_t)-1:0];
		if ($urandom_range(19) != 0) begin
			r.kind = 6'($urandom_range(OP_XORI));
			if ($urandom_range(3) != 0) begin
				r.src_reg_s = 5'($urandom_range(7));
				r.src_reg_t = 5'($urandom_range(7));
				r.dst_reg_d = 5'($urandom_range(7));
			end
			if (r.kind inside {OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW, OP_LWU,
					OP_SB, OP_SH, OP_SW} && $urandom_range(3) != 0)
				r.immediate = 16'($urandom_range(63));
		end
		return r;
	endfunction

	task automatic run_random(int n);
		repeat (n) send_request(random_request());
	endtask

	// stop offering and wait until every expected result has come back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		sb = new();
		sb.clear_state();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_phase = 1'b0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: build operands, extremes, all special cases
		send_request(make_request(OP_LUI, 0, 1, 0, 16'h8000, 0));      // r1 = 0x80000000
		send_request(make_request(OP_ADDIU, 0, 2, 0, 16'hFFFF, 0));    // r2 = -1
		send_request(make_request(OP_ORI, 0, 3, 0, 16'hFFFF, 0));      // zero-extended
		send_request(make_request(OP_ADD, 1, 2, 4, 0, 0));             // wraps, no trap
		send_request(make_request(OP_DIV, 1, 2, 0, 0, 0));             // most negative / -1
		send_request(make_request(OP_DIV, 2, 0, 0, 0, 0));             // divide by zero
		send_request(make_request(OP_DIVU, 1, 0, 0, 0, 0));
		send_request(make_request(OP_DIV, 4, 3, 0, 0, 0));             // nonzero remainder
		send_request(make_request(OP_DIVU, 2, 3, 0, 0, 0));
		send_request(make_request(OP_MULT, 1, 1, 0, 0, 0));
		send_request(make_request(OP_MULTU, 2, 2, 0, 0, 0));
		send_request(make_request(OP_MFHI, 0, 0, 5, 0, 0));
		send_request(make_request(OP_MFLO, 0, 0, 6, 0, 0));
		send_request(make_request(OP_MTHI, 2, 0, 0, 0, 0));
		send_request(make_request(OP_MTLO, 1, 0, 0, 0, 0));
		send_request(make_request(OP_ADDI, 2, 0, 0, 16'h7FFF, 0));     // write to r0 dropped
		send_request(make_request(OP_SW, 0, 1, 0, 16'h0008, 0));
		send_request(make_request(OP_SB, 0, 3, 0, 16'h0009, 0));       // byte lane 1
		send_request(make_request(OP_SH, 0, 2, 0, 16'h000A, 0));       // half lane at bit 1
		send_request(make_request(OP_LB, 0, 7, 0, 16'h0009, 0));
		send_request(make_request(OP_LHU, 0, 8, 0, 16'h000A, 0));
		send_request(make_request(OP_LWU, 0, 9, 0, 16'hFFF8, 0));      // negative offset wraps
		send_request(make_request(OP_SLLV, 2, 2, 10, 0, 0));           // only low 5 bits of rs
		send_request(make_request(OP_SRA, 0, 1, 11, 0, 31));
		send_request(make_request(OP_SLTIU, 0, 12, 0, 16'h8000, 0));
		send_request(make_request(6'd63, 31, 31, 31, 16'hFFFF, 31));   // unsupported kind

		send_idle_pct = 7;
		recv_idle_pct = 73;
		run_random(250);
		// long receiver stall while requests keep coming, to fill the queue
		hold_phase = 1'b1;
		send_idle_pct = 73;
		recv_idle_pct = 7;
		run_random(250);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(250);

		drain();
		repeat (50) @(posedge clk);
		$display("sent %0d requests covering all opcodes, checked %0d results",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mie_pkg.sv
rtl/core/mie_ram.sv
rtl/core/mie_front.sv
rtl/core/mie_queue.sv
rtl/core/mie_back.sv
rtl/core/mips_integer_execute_unit_top.sv
test/mips_integer_execute_unit_top_tb.sv
